>>> hdl/epc_pkg.sv
// Package for the elastic particle collision block: payload structs,
// register indexes and fixed arithmetic widths. No dependencies.
package epc_pkg;

   localparam int POS_W  = 32;  // Q16.16 coordinates and velocities
   localparam int DIFF_W = 33;  // exact difference of two coordinates
   localparam int CD_W   = 26;  // offset component once contact range is known
   localparam int SQ_W   = 51;  // squared distance
   localparam int DOT_W  = 59;  // signed dot product
   localparam int DOTM_W = 58;  // dot product magnitude
   localparam int HALF_W = 29;  // half of the dot magnitude for partial products
   localparam int K_W    = 34;  // |offset| * 2 * mass
   localparam int PP_W   = 63;  // one partial product
   localparam int NUM_W  = 92;  // dividend
   localparam int DEN_W  = 60;  // divisor
   localparam int QUO_W  = 35;  // quotient bits, bounded by 2*|dv|*m/msum
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   typedef enum logic [CSR_AW-1:0] {
      CSR_BOX_LEFT, CSR_BOX_TOP, CSR_BOX_RIGHT, CSR_BOX_BOTTOM,
      CSR_RED_MASS, CSR_BLUE_MASS, CSR_RED_RADIUS, CSR_BLUE_RADIUS
   } csr_idx_type;

   typedef enum logic {
      CMD_COLLIDE = 1'b0,
      CMD_WALL    = 1'b1
   } cmd_type;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] pos_a_x;
      logic signed [31:0] pos_a_y;
      logic signed [31:0] vel_a_x;
      logic signed [31:0] vel_a_y;
      logic               kind_a;
      logic signed [31:0] pos_b_x;
      logic signed [31:0] pos_b_y;
      logic signed [31:0] vel_b_x;
      logic signed [31:0] vel_b_y;
      logic               kind_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_vel_a_x;
      logic signed [31:0] new_vel_a_y;
      logic signed [31:0] new_vel_b_x;
      logic signed [31:0] new_vel_b_y;
      logic signed [31:0] new_pos_a_x;
      logic signed [31:0] new_pos_a_y;
      logic               collided;
   } rsp_type;

   // Result without the collision update, plus what the final stage needs.
   typedef struct packed {
      rsp_type base;
      logic    hit;
      logic    dx_neg;
      logic    dx_pos;
      logic    dy_neg;
      logic    dy_pos;
   } side_type;

endpackage

>>> hdl/epc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on epc_pkg for the operand widths.
module epc_div
   import epc_pkg::*;
(
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   logic [DEN_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] low_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];

   logic [DEN_W-1:0] rem_in [QUO_W];
   logic [QUO_W-1:0] low_in [QUO_W];
   logic [QUO_W-1:0] quo_in [QUO_W];
   logic [DEN_W-1:0] den_in [QUO_W];

   always_comb begin
      logic [DEN_W-1:0] r;
      logic [QUO_W-1:0] l;
      logic [QUO_W-1:0] q;
      logic [DEN_W-1:0] d;
      logic [DEN_W:0]   trial;
      for (int j = 0; j < QUO_W; j++) begin
         if (j == 0) begin
            // top bits are below the divisor since the quotient fits QUO_W bits
            r = DEN_W'(num[NUM_W-1:QUO_W]);
            l = num[QUO_W-1:0];
            q = '0;
            d = den;
         end else begin
            r = rem_ff[j-1];
            l = low_ff[j-1];
            q = quo_ff[j-1];
            d = den_ff[j-1];
         end
         trial = {r, l[QUO_W-1]};
         if (trial >= {1'b0, d}) begin
            rem_in[j] = DEN_W'(trial - {1'b0, d});
            quo_in[j] = {q[QUO_W-2:0], 1'b1};
         end else begin
            rem_in[j] = trial[DEN_W-1:0];
            quo_in[j] = {q[QUO_W-2:0], 1'b0};
         end
         low_in[j] = {l[QUO_W-2:0], 1'b0};
         den_in[j] = d;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < QUO_W; j++) begin
         rem_ff[j] <= rem_in[j];
         low_ff[j] <= low_in[j];
         quo_ff[j] <= quo_in[j];
         den_ff[j] <= den_in[j];
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

>>> hdl/elastic_particle_collision.sv
// Top level of the 2D elastic collision kernel: contact test, dot product,
// impulse division and wall bounce. Depends on epc_pkg and epc_div.
//
//  channel  ports                              transfer when
//  -------  ---------------------------------  -----------------------
//  request  start, busy, req_payload           start && !busy
//  result   rsp_strobe, rsp_payload            rsp_strobe (no stall)
//  config   csr_we, csr_index, csr_wdata       csr_we
//
// One item enters every cycle; each result passes six arithmetic stages,
// 35 divider stages and one output stage.
// The depth is set by the bit-per-stage impulse divider.
// Reset is synchronous and clears the stage valid bits and the configuration registers.
// busy is never raised: nothing downstream can hold results off.
module elastic_particle_collision
   import epc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_payload,
   output logic              rsp_strobe,
   output rsp_type           rsp_payload,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam int LAT = 7 + QUO_W;

   // ---------------- configuration registers ----------------
   logic signed [31:0] box_left_ff, box_top_ff, box_right_ff, box_bottom_ff;
   logic [7:0]         red_mass_ff, blue_mass_ff, red_radius_ff, blue_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_left_ff    <= 32'sd0;
         box_top_ff     <= 32'sd0;
         box_right_ff   <= 32'sd41943040;
         box_bottom_ff  <= 32'sd31457280;
         red_mass_ff    <= 8'd1;
         blue_mass_ff   <= 8'd4;
         red_radius_ff  <= 8'd3;
         blue_radius_ff <= 8'd6;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_BOX_LEFT:    box_left_ff    <= csr_wdata;
            CSR_BOX_TOP:     box_top_ff     <= csr_wdata;
            CSR_BOX_RIGHT:   box_right_ff   <= csr_wdata;
            CSR_BOX_BOTTOM:  box_bottom_ff  <= csr_wdata;
            CSR_RED_MASS:    red_mass_ff    <= csr_wdata[7:0];
            CSR_BLUE_MASS:   blue_mass_ff   <= csr_wdata[7:0];
            CSR_RED_RADIUS:  red_radius_ff  <= csr_wdata[7:0];
            CSR_BLUE_RADIUS: blue_radius_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;
   logic take;
   assign take = start && !busy;

   // ---------------- stage A: differences, range gate, wall tests ----------------
   logic                     a_vld_ff;
   req_type                  a_req_ff;
   logic signed [CD_W-1:0]   a_dx_ff, a_dy_ff;
   logic signed [DIFF_W-1:0] a_dvx_ff, a_dvy_ff;
   logic [7:0]               a_ma_ff, a_mb_ff;
   logic [8:0]               a_rs_ff, a_msum_ff;
   logic                     a_gate_ff, a_xref_ff, a_yref_ff;

   logic signed [DIFF_W-1:0] a_dx_in, a_dy_in;
   logic [7:0]               a_ma_in, a_mb_in, a_ra_in, a_rb_in;
   logic [8:0]               a_rs_in, a_msum_in;
   logic signed [DIFF_W:0]   lim_s, dx_w, dy_w;
   logic                     a_gate_in, a_xref_in, a_yref_in;
   logic signed [33:0]       r_s, left_lim, right_lim, top_lim, bot_lim;
   logic signed [33:0]       pax_w, pay_w;

   always_comb begin
      a_ma_in   = req_payload.kind_a ? blue_mass_ff : red_mass_ff;
      a_mb_in   = req_payload.kind_b ? blue_mass_ff : red_mass_ff;
      a_ra_in   = req_payload.kind_a ? blue_radius_ff : red_radius_ff;
      a_rb_in   = req_payload.kind_b ? blue_radius_ff : red_radius_ff;
      a_rs_in   = {1'b0, a_ra_in} + {1'b0, a_rb_in};
      a_msum_in = {1'b0, a_ma_in} + {1'b0, a_mb_in};
      a_dx_in   = DIFF_W'(req_payload.pos_a_x) - DIFF_W'(req_payload.pos_b_x);
      a_dy_in   = DIFF_W'(req_payload.pos_a_y) - DIFF_W'(req_payload.pos_b_y);
      lim_s     = $signed({9'd0, a_rs_in, 16'd0});
      dx_w      = (DIFF_W+1)'(a_dx_in);
      dy_w      = (DIFF_W+1)'(a_dy_in);
      a_gate_in = (a_dx_in != '0 || a_dy_in != '0) && a_msum_in != '0 &&
                  dx_w <= lim_s && dx_w >= -lim_s && dy_w <= lim_s && dy_w >= -lim_s;

      r_s       = $signed({2'b0, a_ra_in, 16'd0});
      left_lim  = 34'(box_left_ff) + r_s;
      right_lim = 34'(box_right_ff) - r_s;
      top_lim   = 34'(box_top_ff) + r_s;
      bot_lim   = 34'(box_bottom_ff) - r_s;
      pax_w     = 34'(req_payload.pos_a_x);
      pay_w     = 34'(req_payload.pos_a_y);
      a_xref_in = (pax_w <= left_lim && req_payload.vel_a_x < 0) ||
                  (pax_w >= right_lim && req_payload.vel_a_x > 0);
      a_yref_in = (pay_w <= top_lim && req_payload.vel_a_y < 0) ||
                  (pay_w >= bot_lim && req_payload.vel_a_y > 0);
   end

   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else       a_vld_ff <= take;
      a_req_ff  <= req_payload;
      a_dx_ff   <= a_dx_in[CD_W-1:0];
      a_dy_ff   <= a_dy_in[CD_W-1:0];
      a_dvx_ff  <= DIFF_W'(req_payload.vel_a_x) - DIFF_W'(req_payload.vel_b_x);
      a_dvy_ff  <= DIFF_W'(req_payload.vel_a_y) - DIFF_W'(req_payload.vel_b_y);
      a_ma_ff   <= a_ma_in;
      a_mb_ff   <= a_mb_in;
      a_rs_ff   <= a_rs_in;
      a_msum_ff <= a_msum_in;
      a_gate_ff <= a_gate_in;
      a_xref_ff <= a_xref_in;
      a_yref_ff <= a_yref_in;
   end

   // ---------------- stage B: squares, dot terms, reflected velocity ----------------
   logic                     b_vld_ff;
   req_type                  b_req_ff;
   logic [SQ_W-2:0]          b_dx2_ff, b_dy2_ff;
   logic signed [DOTM_W-1:0] b_px_ff, b_py_ff;
   logic [17:0]              b_thr_ff;
   logic signed [CD_W-1:0]   b_dx_ff, b_dy_ff;
   logic [7:0]               b_ma_ff, b_mb_ff;
   logic [8:0]               b_msum_ff;
   logic                     b_gate_ff, b_xref_ff, b_yref_ff;
   logic signed [31:0]       b_nvx_ff, b_nvy_ff;

   logic signed [2*CD_W-1:0]        sq_x, sq_y;
   logic signed [DIFF_W+CD_W-1:0]   pr_x, pr_y;

   function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
      neg_sat = (v == 32'sh8000_0000) ? 32'sh7fff_ffff : -v;
   endfunction

   always_comb begin
      sq_x = a_dx_ff * a_dx_ff;
      sq_y = a_dy_ff * a_dy_ff;
      pr_x = a_dvx_ff * a_dx_ff;
      pr_y = a_dvy_ff * a_dy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else       b_vld_ff <= a_vld_ff;
      b_req_ff  <= a_req_ff;
      b_dx2_ff  <= sq_x[SQ_W-2:0];
      b_dy2_ff  <= sq_y[SQ_W-2:0];
      b_px_ff   <= pr_x[DOTM_W-1:0];
      b_py_ff   <= pr_y[DOTM_W-1:0];
      b_thr_ff  <= a_rs_ff * a_rs_ff;
      b_dx_ff   <= a_dx_ff;
      b_dy_ff   <= a_dy_ff;
      b_ma_ff   <= a_ma_ff;
      b_mb_ff   <= a_mb_ff;
      b_msum_ff <= a_msum_ff;
      b_gate_ff <= a_gate_ff;
      b_xref_ff <= a_xref_ff && a_req_ff.cmd == CMD_WALL;
      b_yref_ff <= a_yref_ff && a_req_ff.cmd == CMD_WALL;
      b_nvx_ff  <= a_xref_ff ? neg_sat(a_req_ff.vel_a_x) : a_req_ff.vel_a_x;
      b_nvy_ff  <= a_yref_ff ? neg_sat(a_req_ff.vel_a_y) : a_req_ff.vel_a_y;
   end

   // ---------------- stage C: sums, magnitudes, bypass result ----------------
   logic                    c_vld_ff;
   logic [SQ_W-1:0]         c_dist2_ff;
   logic signed [DOT_W-1:0] c_dot_ff;
   logic [17:0]             c_thr_ff;
   logic [CD_W-2:0]         c_adx_ff, c_ady_ff;
   logic [7:0]              c_ma_ff, c_mb_ff;
   logic [8:0]              c_msum_ff;
   logic                    c_gate_ff;
   side_type                c_side_ff;

   side_type                c_side_in;
   logic signed [32:0]      npx_w, npy_w;

   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      if (v > 33'sh0_7fff_ffff)       sat33 = 32'sh7fff_ffff;
      else if (v < -33'sh0_8000_0000) sat33 = 32'sh8000_0000;
      else                            sat33 = v[31:0];
   endfunction

   always_comb begin
      npx_w = 33'(b_req_ff.pos_a_x) + 33'(b_nvx_ff);
      npy_w = 33'(b_req_ff.pos_a_y) + 33'(b_nvy_ff);
      c_side_in.base.new_vel_b_x = b_req_ff.vel_b_x;
      c_side_in.base.new_vel_b_y = b_req_ff.vel_b_y;
      if (b_req_ff.cmd == CMD_WALL) begin
         c_side_in.base.new_vel_a_x = b_nvx_ff;
         c_side_in.base.new_vel_a_y = b_nvy_ff;
         c_side_in.base.new_pos_a_x = sat33(npx_w);
         c_side_in.base.new_pos_a_y = sat33(npy_w);
         c_side_in.base.collided    = b_xref_ff || b_yref_ff;
      end else begin
         c_side_in.base.new_vel_a_x = b_req_ff.vel_a_x;
         c_side_in.base.new_vel_a_y = b_req_ff.vel_a_y;
         c_side_in.base.new_pos_a_x = b_req_ff.pos_a_x;
         c_side_in.base.new_pos_a_y = b_req_ff.pos_a_y;
         c_side_in.base.collided    = 1'b0;
      end
      c_side_in.hit    = b_gate_ff && b_req_ff.cmd == CMD_COLLIDE;  // refined in D
      c_side_in.dx_neg = b_dx_ff < 0;
      c_side_in.dx_pos = b_dx_ff > 0;
      c_side_in.dy_neg = b_dy_ff < 0;
      c_side_in.dy_pos = b_dy_ff > 0;
   end

   always_ff @(posedge clock) begin
      if (reset) c_vld_ff <= 1'b0;
      else       c_vld_ff <= b_vld_ff;
      c_dist2_ff <= {1'b0, b_dx2_ff} + {1'b0, b_dy2_ff};
      c_dot_ff   <= DOT_W'(b_px_ff) + DOT_W'(b_py_ff);
      c_thr_ff   <= b_thr_ff;
      c_adx_ff   <= b_dx_ff[CD_W-1] ? (CD_W-1)'(-b_dx_ff) : b_dx_ff[CD_W-2:0];
      c_ady_ff   <= b_dy_ff[CD_W-1] ? (CD_W-1)'(-b_dy_ff) : b_dy_ff[CD_W-2:0];
      c_ma_ff    <= b_ma_ff;
      c_mb_ff    <= b_mb_ff;
      c_msum_ff  <= b_msum_ff;
      c_gate_ff  <= b_gate_ff;
      c_side_ff  <= c_side_in;
   end

   // ---------------- stage D: contact decision, divisor, scale factors ----------------
   logic                d_vld_ff;
   logic [DOTM_W-1:0]   d_adot_ff;
   logic [DEN_W-1:0]    d_den_ff;
   logic [K_W-1:0]      d_kax_ff, d_kay_ff, d_kbx_ff, d_kby_ff;
   side_type            d_side_ff;

   side_type            d_side_in;
   logic                contact;

   always_comb begin
      contact   = c_dist2_ff <= {c_thr_ff, 32'd0} && c_dot_ff < 0;
      d_side_in = c_side_ff;
      d_side_in.hit = c_side_ff.hit && contact;
      d_side_in.base.collided = c_side_ff.base.collided || d_side_in.hit;
   end

   always_ff @(posedge clock) begin
      if (reset) d_vld_ff <= 1'b0;
      else       d_vld_ff <= c_vld_ff;
      d_adot_ff <= c_dot_ff[DOT_W-1] ? DOTM_W'(-c_dot_ff) : c_dot_ff[DOTM_W-1:0];
      d_den_ff  <= DEN_W'(c_msum_ff * c_dist2_ff);
      d_kax_ff  <= K_W'(c_adx_ff * {c_mb_ff, 1'b0});
      d_kay_ff  <= K_W'(c_ady_ff * {c_mb_ff, 1'b0});
      d_kbx_ff  <= K_W'(c_adx_ff * {c_ma_ff, 1'b0});
      d_kby_ff  <= K_W'(c_ady_ff * {c_ma_ff, 1'b0});
      d_side_ff <= d_side_in;
   end

   // ---------------- stage E: partial products over two dot halves ----------------
   logic             e_vld_ff;
   logic [PP_W-1:0]  e_lo_ff [4];
   logic [PP_W-1:0]  e_hi_ff [4];
   logic [DEN_W-1:0] e_den_ff;
   side_type         e_side_ff;
   logic [K_W-1:0]   k_sel [4];

   assign k_sel[0] = d_kax_ff;
   assign k_sel[1] = d_kay_ff;
   assign k_sel[2] = d_kbx_ff;
   assign k_sel[3] = d_kby_ff;

   always_ff @(posedge clock) begin
      if (reset) e_vld_ff <= 1'b0;
      else       e_vld_ff <= d_vld_ff;
      for (int i = 0; i < 4; i++) begin
         e_lo_ff[i] <= PP_W'(k_sel[i] * d_adot_ff[HALF_W-1:0]);
         e_hi_ff[i] <= PP_W'(k_sel[i] * d_adot_ff[DOTM_W-1:HALF_W]);
      end
      e_den_ff  <= d_den_ff;
      e_side_ff <= d_side_ff;
   end

   // ---------------- stage F: dividends ----------------
   logic             f_vld_ff;
   logic [NUM_W-1:0] f_num_ff [4];
   logic [DEN_W-1:0] f_den_ff;
   side_type         f_side_ff;

   always_ff @(posedge clock) begin
      if (reset) f_vld_ff <= 1'b0;
      else       f_vld_ff <= e_vld_ff;
      for (int i = 0; i < 4; i++) begin
         f_num_ff[i] <= NUM_W'(e_lo_ff[i]) + {e_hi_ff[i], {HALF_W{1'b0}}};
      end
      f_den_ff  <= e_den_ff;
      f_side_ff <= e_side_ff;
   end

   // ---------------- impulse dividers and side delay line ----------------
   logic [QUO_W-1:0] quo [4];

   for (genvar g = 0; g < 4; g++) begin : g_div
      epc_div u_div (
         .clock (clock),
         .num   (f_num_ff[g]),
         .den   (f_den_ff),
         .quo   (quo[g])
      );
   end

   logic     dl_vld_ff  [QUO_W];
   side_type dl_side_ff [QUO_W];

   always_ff @(posedge clock) begin
      for (int j = 0; j < QUO_W; j++) begin
         if (reset)       dl_vld_ff[j] <= 1'b0;
         else if (j == 0) dl_vld_ff[j] <= f_vld_ff;
         else             dl_vld_ff[j] <= dl_vld_ff[j-1];
         dl_side_ff[j] <= (j == 0) ? f_side_ff : dl_side_ff[j-1];
      end
   end

   // ---------------- output stage: apply impulses, saturate ----------------
   side_type side_q;
   rsp_type  rsp_in;

   function automatic logic signed [31:0] apply(input logic signed [31:0] v,
                                                input logic [QUO_W-1:0] q,
                                                input logic sub);
      logic signed [QUO_W+1:0] w;
      w = sub ? (QUO_W+2)'(v) - $signed({2'b0, q}) : (QUO_W+2)'(v) + $signed({2'b0, q});
      if (w > (QUO_W+2)'(32'sh7fff_ffff))      apply = 32'sh7fff_ffff;
      else if (w < (QUO_W+2)'(32'sh8000_0000)) apply = 32'sh8000_0000;
      else                                     apply = w[31:0];
   endfunction

   always_comb begin
      side_q = dl_side_ff[QUO_W-1];
      rsp_in = side_q.base;
      if (side_q.hit) begin
         // A moves with the offset sign, B against it
         rsp_in.new_vel_a_x = apply(side_q.base.new_vel_a_x, quo[0], side_q.dx_neg);
         rsp_in.new_vel_a_y = apply(side_q.base.new_vel_a_y, quo[1], side_q.dy_neg);
         rsp_in.new_vel_b_x = apply(side_q.base.new_vel_b_x, quo[2], side_q.dx_pos);
         rsp_in.new_vel_b_y = apply(side_q.base.new_vel_b_y, quo[3], side_q.dy_pos);
      end
   end

   logic    rsp_strobe_ff;
   rsp_type rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else       rsp_strobe_ff <= dl_vld_ff[QUO_W-1];
      rsp_payload_ff <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------- assertions ----------------
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(take, LAT))
      else $error("result transfer without a matching request");

   a_quiet_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.collided |->
         rsp_payload.new_vel_a_x == $past(req_payload.vel_a_x, LAT) &&
         rsp_payload.new_vel_b_y == $past(req_payload.vel_b_y, LAT))
      else $error("velocity changed without a collision");

   a_collide_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(req_payload.cmd, LAT) == CMD_COLLIDE |->
         rsp_payload.new_pos_a_x == $past(req_payload.pos_a_x, LAT))
      else $error("collide command moved particle A");

endmodule

>>> tb/elastic_particle_collision_tb.sv
// Self-checking testbench for the elastic particle collision kernel.
// Depends on epc_pkg and the elastic_particle_collision RTL only.
`timescale 1ns / 100ps

module elastic_particle_collision_tb;
   import epc_pkg::*;

   localparam int LIMIT = 400000;
   localparam int LATENCY = 42;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_payload;
   logic              rsp_strobe;
   rsp_type           rsp_payload;
   logic              csr_we;
   logic [CSR_AW-1:0] csr_index;
   logic [CSR_DW-1:0] csr_wdata;

   elastic_particle_collision dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // copy of the register file used by the predictor
   logic signed [31:0] wall_left, wall_top, wall_right, wall_bottom;
   logic [7:0] mass_red, mass_blue, rad_red, rad_blue;

   req_type pending_pairs[$];
   rsp_type expected_motion[$];
   int errors = 0;
   int cycles = 0;
   int gap_left = 0;
   bit gaps_on = 1;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic logic signed [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // trunc(c * 2 * m_other * dot / (msum * dist2)), exact in 128 bits
   function automatic longint impulse_of(longint c, longint m_other, longint dot,
                                         longint msum, longint dist2);
      logic [127:0] ac, ad, mo, num, den, q;
      ac = (c < 0) ? -c : c;
      ad = (dot < 0) ? -dot : dot;
      mo = m_other;
      num = ac * 128'd2 * mo * ad;
      den = 128'(msum) * 128'(dist2);
      q = num / den;
      return ((c < 0) != (dot < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic rsp_type predict_motion(req_type it);
      rsp_type r;
      longint pax, pay, vax, vay, pbx, pby, vbx, vby;
      longint ma, mb, ra, rb, dx, dy, lim, msum, dist2, thr, dot, rr;
      longint nvax, nvay, nvbx, nvby, npx, npy;
      bit hit;
      pax = it.pos_a_x; pay = it.pos_a_y; vax = it.vel_a_x; vay = it.vel_a_y;
      pbx = it.pos_b_x; pby = it.pos_b_y; vbx = it.vel_b_x; vby = it.vel_b_y;
      ma = it.kind_a ? mass_blue : mass_red;
      mb = it.kind_b ? mass_blue : mass_red;
      ra = it.kind_a ? rad_blue : rad_red;
      rb = it.kind_b ? rad_blue : rad_red;
      nvax = vax; nvay = vay; nvbx = vbx; nvby = vby; npx = pax; npy = pay;
      hit = 0;
      if (it.cmd == CMD_COLLIDE) begin
         dx = pax - pbx;
         dy = pay - pby;
         lim = (ra + rb) << 16;
         msum = ma + mb;
         if ((dx != 0 || dy != 0) && msum != 0 && dx <= lim && dx >= -lim &&
             dy <= lim && dy >= -lim) begin
            dist2 = dx * dx + dy * dy;
            thr = ((ra + rb) * (ra + rb)) << 32;
            dot = (vax - vbx) * dx + (vay - vby) * dy;
            if (dist2 <= thr && dot < 0) begin
               nvax = vax - impulse_of(dx, mb, dot, msum, dist2);
               nvay = vay - impulse_of(dy, mb, dot, msum, dist2);
               nvbx = vbx - impulse_of(-dx, ma, dot, msum, dist2);
               nvby = vby - impulse_of(-dy, ma, dot, msum, dist2);
               hit = 1;
            end
         end
      end else begin
         rr = ra << 16;
         if ((pax <= longint'(wall_left) + rr && vax < 0) ||
             (pax >= longint'(wall_right) - rr && vax > 0)) begin
            nvax = -vax;
            hit = 1;
         end
         if ((pay <= longint'(wall_top) + rr && vay < 0) ||
             (pay >= longint'(wall_bottom) - rr && vay > 0)) begin
            nvay = -vay;
            hit = 1;
         end
         nvax = sat32(nvax);
         nvay = sat32(nvay);
         npx = pax + nvax;
         npy = pay + nvay;
      end
      r.new_vel_a_x = sat32(nvax);
      r.new_vel_a_y = sat32(nvay);
      r.new_vel_b_x = sat32(nvbx);
      r.new_vel_b_y = sat32(nvby);
      r.new_pos_a_x = sat32(npx);
      r.new_pos_a_y = sat32(npy);
      r.collided = hit;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h, want %h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // driver: hold the item until transfer, then advance after a drawn gap
   always @(posedge clock) begin
      logic next_start;
      next_start = start;
      if (reset) begin
         next_start = 1'b0;
      end else begin
         if (start && !busy) begin
            expected_motion.push_back(predict_motion(req_payload));
            next_start = 1'b0;
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_pairs.size() > 0) begin
               req_payload <= pending_pairs.pop_front();
               next_start = 1'b1;
               gap_left = gaps_on ? $urandom_range(0, 12) : 0;
            end
         end
      end
      start <= next_start;
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_motion.size() == 0) begin
            $display("unexpected result at cycle %0d", cycles);
            errors++;
         end else begin
            want = expected_motion.pop_front();
            if (rsp_payload.new_vel_a_x !== want.new_vel_a_x)
               report_mismatch("new_vel_a_x", rsp_payload.new_vel_a_x, want.new_vel_a_x);
            if (rsp_payload.new_vel_a_y !== want.new_vel_a_y)
               report_mismatch("new_vel_a_y", rsp_payload.new_vel_a_y, want.new_vel_a_y);
            if (rsp_payload.new_vel_b_x !== want.new_vel_b_x)
               report_mismatch("new_vel_b_x", rsp_payload.new_vel_b_x, want.new_vel_b_x);
            if (rsp_payload.new_vel_b_y !== want.new_vel_b_y)
               report_mismatch("new_vel_b_y", rsp_payload.new_vel_b_y, want.new_vel_b_y);
            if (rsp_payload.new_pos_a_x !== want.new_pos_a_x)
               report_mismatch("new_pos_a_x", rsp_payload.new_pos_a_x, want.new_pos_a_x);
            if (rsp_payload.new_pos_a_y !== want.new_pos_a_y)
               report_mismatch("new_pos_a_y", rsp_payload.new_pos_a_y, want.new_pos_a_y);
            if (rsp_payload.collided !== want.collided)
               report_mismatch("collided", 32'(rsp_payload.collided), 32'(want.collided));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_reg(csr_idx_type idx, logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BOX_LEFT:    wall_left = value;
         CSR_BOX_TOP:     wall_top = value;
         CSR_BOX_RIGHT:   wall_right = value;
         CSR_BOX_BOTTOM:  wall_bottom = value;
         CSR_RED_MASS:    mass_red = value[7:0];
         CSR_BLUE_MASS:   mass_blue = value[7:0];
         CSR_RED_RADIUS:  rad_red = value[7:0];
         default:         rad_blue = value[7:0];
      endcase
   endtask

   task automatic set_box(logic [31:0] l, logic [31:0] t, logic [31:0] r, logic [31:0] b);
      write_reg(CSR_BOX_LEFT, l);
      write_reg(CSR_BOX_TOP, t);
      write_reg(CSR_BOX_RIGHT, r);
      write_reg(CSR_BOX_BOTTOM, b);
   endtask

   task automatic set_bodies(int mr, int mbl, int rr, int rbl);
      write_reg(CSR_RED_MASS, mr);
      write_reg(CSR_BLUE_MASS, mbl);
      write_reg(CSR_RED_RADIUS, rr);
      write_reg(CSR_BLUE_RADIUS, rbl);
   endtask

   task automatic wait_idle();
      while (pending_pairs.size() > 0 || expected_motion.size() > 0 || start)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   function automatic req_type pair(cmd_type c, int pax, int pay, int vax, int vay,
                                    bit ka, int pbx, int pby, int vbx, int vby, bit kb);
      req_type it;
      it.cmd = c;
      it.pos_a_x = pax; it.pos_a_y = pay; it.vel_a_x = vax; it.vel_a_y = vay;
      it.kind_a = ka;
      it.pos_b_x = pbx; it.pos_b_y = pby; it.vel_b_x = vbx; it.vel_b_y = vby;
      it.kind_b = kb;
      return it;
   endfunction

   function automatic int rand_vel();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return $urandom_range(0, 1 << 22) - (1 << 21);
   endfunction

   function automatic int near(int base);
      return base + $urandom_range(0, 8 << 16) - (4 << 16);
   endfunction

   function automatic req_type random_pair();
      req_type it;
      int sum, span;
      bit ka, kb;
      ka = $urandom_range(0, 1);
      kb = $urandom_range(0, 1);
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7, 8: begin
            // contact range, content random; some just outside it
            sum = (ka ? rad_blue : rad_red) + (kb ? rad_blue : rad_red);
            span = ($urandom_range(0, 5) == 0) ? 2 * sum : sum;
            it = pair(CMD_COLLIDE, $urandom_range(0, 1 << 30) - (1 << 29),
                      $urandom_range(0, 1 << 30) - (1 << 29), rand_vel(), rand_vel(), ka,
                      0, 0, rand_vel(), rand_vel(), kb);
            it.pos_b_x = it.pos_a_x - ($urandom_range(0, 2 * span << 16) - (span << 16));
            it.pos_b_y = it.pos_a_y - ($urandom_range(0, 2 * span << 16) - (span << 16));
         end
         9, 10, 11, 12, 13, 14: begin
            sum = (ka ? rad_blue : rad_red) << 16;
            it = pair(CMD_WALL,
                      $urandom_range(0, 1) ? near(wall_left + sum) : near(wall_right - sum),
                      $urandom_range(0, 1) ? near(wall_top + sum) : near(wall_bottom - sum),
                      rand_vel(), rand_vel(), ka, $urandom, $urandom, $urandom, $urandom, kb);
         end
         default: begin
            it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom};
         end
      endcase
      return it;
   endfunction

   task automatic load_directed();
      int one;
      one = 1 << 16;
      // head-on approach along x with unequal kinds, then an oblique approach with equal kinds
      pending_pairs.push_back(pair(CMD_COLLIDE, 0, 0, one, 0, 0, 4 * one, 0, -one, 0, 1));
      pending_pairs.push_back(pair(CMD_COLLIDE, 0, 0, one, one, 1, 5 * one, 3 * one,
                                   -one, -2 * one, 1));
      // separating pair
      pending_pairs.push_back(pair(CMD_COLLIDE, 0, 0, -one, 0, 0, 4 * one, 0, one, 0, 0));
      // coincident positions
      pending_pairs.push_back(pair(CMD_COLLIDE, 7, 7, one, 0, 0, 7, 7, -one, 0, 1));
      // exactly touching and one unit past touching
      pending_pairs.push_back(pair(CMD_COLLIDE, 0, 0, one, 0, 0, 6 * one, 0, -one, 0, 0));
      pending_pairs.push_back(pair(CMD_COLLIDE, 0, 0, one, 0, 0, 6 * one + 1, 0, -one, 0, 0));
      // extreme velocities in contact, and extreme positions
      pending_pairs.push_back(pair(CMD_COLLIDE, 0, 0, 32'h7fffffff, 32'h7fffffff, 1,
                                   one, one, 32'h80000000, 32'h80000000, 0));
      pending_pairs.push_back(pair(CMD_COLLIDE, 32'h7fffffff, 32'h80000000, 0, 0, 0,
                                   32'h80000000, 32'h7fffffff, 0, 0, 1));
      pending_pairs.push_back(pair(CMD_COLLIDE, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                                   32'h80000000, 1, 32'h7ffd0000, 32'h7ffd0000,
                                   32'h7fffffff, 32'h7fffffff, 1));
      // walls: each side, negation of the most negative velocity, no reflect
      pending_pairs.push_back(pair(CMD_WALL, 0, 100 * one, 32'h80000000, 0, 0, 0, 0, 5, 6, 0));
      pending_pairs.push_back(pair(CMD_WALL, 640 * one, 100 * one, one, 0, 1, 0, 0, 0, 0, 1));
      pending_pairs.push_back(pair(CMD_WALL, 100 * one, 0, 0, 32'h80000000, 0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(pair(CMD_WALL, 100 * one, 480 * one, 0, one, 1, 0, 0, 0, 0, 0));
      pending_pairs.push_back(pair(CMD_WALL, 100 * one, 100 * one, one, -one, 0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(pair(CMD_WALL, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                   32'h7fffffff, 1, 0, 0, 0, 0, 1));
      pending_pairs.push_back(pair(CMD_WALL, 32'h80000000, 32'h7fffffff, 32'h80000000,
                                   32'h80000000, 0, 32'h7fffffff, 32'h80000000,
                                   32'h7fffffff, 32'h80000000, 0));
      // wall reached exactly at the inset edge, moving out
      pending_pairs.push_back(pair(CMD_WALL, 3 * one, 3 * one, -1, -1, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic run_random(int n);
      gaps_on = $urandom_range(0, 3) != 0;
      repeat (n) pending_pairs.push_back(random_pair());
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      wall_left = 0; wall_top = 0; wall_right = 41943040; wall_bottom = 31457280;
      mass_red = 1; mass_blue = 4; rad_red = 3; rad_blue = 6;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values first
      load_directed();
      wait_idle();
      run_random(110);

      // extreme box and bodies
      set_box(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
      set_bodies(255, 1, 255, 1);
      run_random(100);
      set_bodies(1, 255, 1, 255);
      run_random(100);
      set_bodies(255, 255, 255, 255);
      run_random(90);

      // inverted box
      set_box(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
      set_bodies(1, 1, 1, 1);
      run_random(90);

      // random settings with sensible boxes
      repeat (4) begin
         set_box($urandom_range(0, 1 << 28) - (1 << 27), $urandom_range(0, 1 << 28) - (1 << 27),
                 0, 0);
         set_box(wall_left, wall_top, wall_left + $urandom_range(1 << 20, 1 << 28),
                 wall_top + $urandom_range(1 << 20, 1 << 28));
         set_bodies($urandom_range(1, 255), $urandom_range(1, 255),
                    $urandom_range(1, 255), $urandom_range(1, 255));
         run_random(90);
      end

      if (errors == 0 && expected_motion.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
